// ===== rtl/ttc_pkg.sv =====
// shared types and constants of the text console cursor controller
`timescale 1ns / 1ps

package ttc_pkg;

  // result command codes
  localparam logic [1:0] CMD_DRAW   = 2'd0;
  localparam logic [1:0] CMD_SCROLL = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic REG_TEXT_COLUMNS = 1'b0;
  localparam logic REG_TEXT_ROWS    = 1'b1;

  // reset values of the configuration registers
  localparam logic [7:0] TEXT_COLUMNS_RESET = 8'd80;
  localparam logic [7:0] TEXT_ROWS_RESET    = 8'd25;

  // character codes
  localparam logic [7:0] CHAR_ESC      = 8'h1B;
  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_UPPER_J  = 8'h4A;
  localparam logic [7:0] CHAR_UPPER_H  = 8'h48;
  localparam logic [7:0] CHAR_DIGIT_2  = 8'h32;
  localparam logic [7:0] CHAR_SEMI     = 8'h3B;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] CHAR_BS       = 8'h08;
  localparam logic [7:0] CHAR_TAB      = 8'h09;
  localparam logic [6:0] GLYPH_SPACE   = 7'h20;

  // escape sequence phase
  typedef enum logic [1:0] {
    ESC_NONE    = 2'd0,
    ESC_SEEN    = 2'd1,
    ESC_BRACKET = 2'd2,
    ESC_PARAM   = 2'd3
  } ttc_esc_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_char;
    logic decode;
    logic line_step;
    logic draw_step;
    logic emit_scroll;
    logic emit_clear;
  } ttc_ctl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic esc_clear;
    logic is_newline;
    logic wants_draw;
    logic in_escape;
    logic wrap;
    logic scroll;
    logic tab_more;
  } ttc_stat_t;

endpackage

// ===== rtl/ttc_char_if.sv =====
// input channel carrying one console byte per beat
`timescale 1ns / 1ps

interface ttc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

// ===== rtl/ttc_cmd_if.sv =====
// output channel carrying one character generator command per beat
`timescale 1ns / 1ps

interface ttc_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] cell_column;
  logic [7:0] cell_row;
  logic [6:0] glyph_code;
  logic       last;

  modport source (output valid, output command, output cell_column, output cell_row,
                  output glyph_code, output last, input ready);
  modport sink (input valid, input command, input cell_column, input cell_row,
                input glyph_code, input last, output ready);
endinterface

// ===== rtl/ttc_ctrl.sv =====
// sequencing state machine of the text console cursor controller
`timescale 1ns / 1ps

module ttc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ttc_pkg::ttc_stat_t stat,
  output ttc_pkg::ttc_ctl_t  ctl
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_LINE   = 6'b000100,
    ST_DRAW   = 6'b001000,
    ST_SCROLL = 6'b010000,
    ST_CLEAR  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctl = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load_char = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        ctl.decode = 1'b1;
        priority if (stat.esc_clear) begin
          state_next = ST_CLEAR;
        end else if (stat.in_escape) begin
          state_next = ST_IDLE;
        end else if (stat.is_newline) begin
          state_next = ST_LINE;
        end else if (stat.wants_draw) begin
          state_next = ST_DRAW;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_LINE: begin
        ctl.line_step = 1'b1;
        state_next = stat.scroll ? ST_SCROLL : ST_IDLE;
      end
      ST_DRAW: begin
        if (stat.out_free) begin
          ctl.draw_step = 1'b1;
          priority if (stat.wrap && stat.scroll) begin
            state_next = ST_SCROLL;
          end else if (stat.tab_more) begin
            state_next = ST_DRAW;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SCROLL: begin
        if (stat.out_free) begin
          ctl.emit_scroll = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (stat.out_free) begin
          ctl.emit_clear = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ttc_datapath.sv =====
// cursor, escape phase, geometry registers and result register
`timescale 1ns / 1ps

module ttc_datapath #(
  parameter int MAX_TEXT_COLUMNS = 255,
  parameter int MAX_TEXT_ROWS    = 255
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic [7:0]         char_code,
  input  ttc_pkg::ttc_ctl_t  ctl,
  output ttc_pkg::ttc_stat_t stat,
  ttc_cmd_if.source          out
);

  localparam logic [7:0] MAX_COLS = 8'(MAX_TEXT_COLUMNS);
  localparam logic [7:0] MAX_ROWS = 8'(MAX_TEXT_ROWS);

  logic [7:0]        text_columns;
  logic [7:0]        text_rows;
  logic [7:0]        cursor_column;
  logic [7:0]        cursor_row;
  ttc_pkg::ttc_esc_t escape_phase;
  logic [7:0]        char_q;

  logic [7:0] cols_clamped;
  logic [7:0] rows_clamped;
  logic       is_esc, is_cr, is_lf, is_bs, is_tab, is_print, is_jh;
  logic [8:0] col_inc;
  logic [8:0] row_inc;
  logic       multi_row;
  logic       wrap;
  logic       scroll;
  logic       tab_more;
  logic [7:0] line_row;
  logic [6:0] glyph;

  // register writes: zero reads as one, large values saturate
  always_comb begin
    cols_clamped = cfg_data;
    if (cfg_data == 8'd0) begin
      cols_clamped = 8'd1;
    end else if (cfg_data > MAX_COLS) begin
      cols_clamped = MAX_COLS;
    end
    rows_clamped = cfg_data;
    if (cfg_data == 8'd0) begin
      rows_clamped = 8'd1;
    end else if (cfg_data > MAX_ROWS) begin
      rows_clamped = MAX_ROWS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_columns <= ttc_pkg::TEXT_COLUMNS_RESET;
      text_rows    <= ttc_pkg::TEXT_ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ttc_pkg::REG_TEXT_COLUMNS: text_columns <= cols_clamped;
        ttc_pkg::REG_TEXT_ROWS:    text_rows    <= rows_clamped;
        default: ;
      endcase
    end
  end

  // byte classes
  assign is_esc   = (char_q == ttc_pkg::CHAR_ESC);
  assign is_cr    = (char_q == ttc_pkg::CHAR_CR);
  assign is_lf    = (char_q == ttc_pkg::CHAR_LF);
  assign is_bs    = (char_q == ttc_pkg::CHAR_BS);
  assign is_tab   = (char_q == ttc_pkg::CHAR_TAB);
  assign is_print = !char_q[7] && (char_q[6:5] != 2'b00);
  assign is_jh    = (char_q == ttc_pkg::CHAR_UPPER_J) || (char_q == ttc_pkg::CHAR_UPPER_H);

  // cursor arithmetic
  assign col_inc   = {1'b0, cursor_column} + 9'd1;
  assign row_inc   = {1'b0, cursor_row} + 9'd1;
  assign multi_row = (text_rows > 8'd1);
  assign wrap      = (col_inc >= {1'b0, text_columns});
  assign scroll    = multi_row && (row_inc >= {1'b0, text_rows - 8'd1});
  assign tab_more  = is_tab && !wrap && (col_inc[1:0] != 2'b00);
  assign glyph     = is_print ? char_q[6:0] : ttc_pkg::GLYPH_SPACE;

  always_comb begin
    if (!multi_row) begin
      line_row = 8'd0;
    end else if (scroll) begin
      line_row = text_rows - 8'd2;
    end else begin
      line_row = row_inc[7:0];
    end
  end

  assign stat.out_free   = !out.valid || out.ready;
  assign stat.in_escape  = (escape_phase != ttc_pkg::ESC_NONE);
  assign stat.esc_clear  = (escape_phase != ttc_pkg::ESC_NONE) && is_jh;
  assign stat.is_newline = is_lf;
  assign stat.wants_draw = is_bs || is_tab || is_print;
  assign stat.wrap       = wrap;
  assign stat.scroll     = scroll;
  assign stat.tab_more   = tab_more;

  always_ff @(posedge clk) begin
    if (ctl.load_char) begin
      char_q <= char_code;
    end
  end

  // cursor and escape phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= 8'd0;
      cursor_row    <= 8'd0;
      escape_phase  <= ttc_pkg::ESC_NONE;
    end else begin
      if (ctl.decode) begin
        unique case (escape_phase)
          ttc_pkg::ESC_NONE: begin
            priority if (is_esc) begin
              escape_phase <= ttc_pkg::ESC_SEEN;
            end else if (is_cr) begin
              cursor_column <= 8'd0;
            end else if (is_bs && cursor_column != 8'd0) begin
              cursor_column <= cursor_column - 8'd1;
            end else begin
              escape_phase <= ttc_pkg::ESC_NONE;
            end
          end
          ttc_pkg::ESC_SEEN: begin
            escape_phase <= (char_q == ttc_pkg::CHAR_LBRACKET) ?
                            ttc_pkg::ESC_BRACKET : ttc_pkg::ESC_NONE;
          end
          ttc_pkg::ESC_BRACKET: begin
            escape_phase <= (char_q == ttc_pkg::CHAR_DIGIT_2 ||
                             char_q == ttc_pkg::CHAR_SEMI) ?
                            ttc_pkg::ESC_PARAM : ttc_pkg::ESC_NONE;
          end
          ttc_pkg::ESC_PARAM: begin
            escape_phase <= ttc_pkg::ESC_NONE;
          end
          default: begin
            escape_phase <= ttc_pkg::ESC_NONE;
          end
        endcase
      end
      if (ctl.line_step) begin
        cursor_column <= 8'd0;
        cursor_row    <= line_row;
      end
      if (ctl.draw_step) begin
        if (wrap) begin
          cursor_column <= 8'd0;
          cursor_row    <= line_row;
        end else if (!is_bs) begin
          cursor_column <= col_inc[7:0];
        end
      end
      if (ctl.emit_clear) begin
        cursor_column <= 8'd0;
        cursor_row    <= 8'd0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (ctl.draw_step || ctl.emit_scroll || ctl.emit_clear) begin
      out.valid <= 1'b1;
    end else if (out.ready) begin
      out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.draw_step) begin
      out.command     <= ttc_pkg::CMD_DRAW;
      out.cell_column <= cursor_column;
      out.cell_row    <= cursor_row;
      out.glyph_code  <= glyph;
      out.last        <= !(wrap && scroll) && !tab_more;
    end else if (ctl.emit_scroll || ctl.emit_clear) begin
      out.command     <= ctl.emit_scroll ? ttc_pkg::CMD_SCROLL : ttc_pkg::CMD_CLEAR;
      out.cell_column <= 8'd0;
      out.cell_row    <= 8'd0;
      out.glyph_code  <= 7'd0;
      out.last        <= 1'b1;
    end
  end

endmodule

// ===== rtl/text_console_cursor_controller.sv =====
// top level of the text console cursor controller
`timescale 1ns / 1ps

// Takes one console byte per beat on char_in and emits character generator
// commands on cmd_out: draw a glyph at a cell, scroll up one text row, or
// clear the screen, with last set on the final command caused by a byte.
// Printable bytes 32..127 draw at the cursor and wrap at text_columns; CR,
// LF, BS and TAB move the cursor (tab stops every 4 columns), and ESC [ 2 J
// or ESC [ H clear the screen and home the cursor. With more than one text
// row, the bottom text row is never written: a new line that reaches it
// scrolls instead. One byte at a time goes through the sequencer: it is
// accepted and decoded, then a newline takes a line step and a printable
// byte, backspace or tab a draw step (a tab one per column up to its tab
// stop), with a trailing scroll when needed. The single result register
// sets the pace of emission: each command waits until the previous one has
// left, and the next byte is accepted while a byte's last command waits.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 columns,
// 1 rows); 0 is taken as 1 and larger values saturate to the maximums.

module text_console_cursor_controller #(
  parameter int MAX_TEXT_COLUMNS = 255,
  parameter int MAX_TEXT_ROWS    = 255
) (
  input  logic       clk,
  input  logic       rst,
  ttc_char_if.sink   char_in,
  ttc_cmd_if.source  cmd_out,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  // command and status between sequencer and datapath
  ttc_pkg::ttc_ctl_t  ctl;
  ttc_pkg::ttc_stat_t stat;
  logic               in_ready;

  // the sequencer only takes a byte when it has finished the previous one
  assign char_in.ready = in_ready;

  ttc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (char_in.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // cursor, escape phase, geometry registers and the result register
  ttc_datapath #(
    .MAX_TEXT_COLUMNS (MAX_TEXT_COLUMNS),
    .MAX_TEXT_ROWS    (MAX_TEXT_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .char_code (char_in.char_code),
    .ctl       (ctl),
    .stat      (stat),
    .out       (cmd_out)
  );

endmodule
